[hw/rtl/ghsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_pkg: shared types and constants for the goal heading/speed unit
// Fixed-point formats, pipeline payload types and the arctangent step table.
// ----------------------------------------------------------------------------
package ghsc_pkg;

    // Number formats
    localparam int FRACTION_BITS   = 16;
    localparam int ROTATION_STAGES = 18;
    localparam int PRE_SHIFT       = 5;

    // Field and datapath widths
    localparam int POS_W      = 24;
    localparam int HEAD_W     = 19;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_STEPS = DIFF_W;
    localparam int XY_W       = DIFF_W + PRE_SHIFT + 4;
    localparam int Z_W        = 36;
    localparam int TURN_W     = 17;
    localparam int ERR_W      = HEAD_W + 1;
    localparam int FWD_W      = 14;
    localparam int DIST_W     = DIFF_W;

    // Cell chain: one root digit per cell, and one rotation in each of the first ROTATION_STAGES cells
    localparam int NUM_CELLS = (ROTATION_STAGES > ROOT_STEPS) ? ROTATION_STAGES : ROOT_STEPS;
    localparam int STAGE_W   = $clog2(NUM_CELLS);
    localparam logic [STAGE_W-1:0] ROT_COUNT  = STAGE_W'(ROTATION_STAGES);
    localparam logic [STAGE_W-1:0] ROOT_COUNT = STAGE_W'(ROOT_STEPS);
    localparam logic [STAGE_W-1:0] ROOT_TOP   = STAGE_W'(ROOT_STEPS - 1);

    // Constants, round half up to FRACTION_BITS
    localparam longint PI_Q       = ((longint'(314159265) << FRACTION_BITS) + 50000000)
                                    / 100000000;
    localparam longint Q_0_05     = ((longint'(5) << FRACTION_BITS) + 50) / 100;
    localparam longint Q_0_1      = ((longint'(1) << FRACTION_BITS) + 5) / 10;
    localparam longint Q_0_2      = ((longint'(2) << FRACTION_BITS) + 5) / 10;
    localparam longint Q_0_3      = ((longint'(3) << FRACTION_BITS) + 5) / 10;
    localparam longint Q_0_8      = ((longint'(8) << FRACTION_BITS) + 5) / 10;
    localparam longint Q_6_1      = ((longint'(61) << FRACTION_BITS) + 5) / 10;
    localparam longint Q_2        = longint'(2) << FRACTION_BITS;

    // Angle thresholds on the heading error
    localparam logic signed [ERR_W-1:0] ERR_PI    = ERR_W'(PI_Q);
    localparam logic signed [ERR_W-1:0] ERR_PI3   = ERR_W'(PI_Q / 3);
    localparam logic signed [ERR_W-1:0] ERR_PI53  = ERR_W'((5 * PI_Q) / 3);
    localparam logic signed [ERR_W-1:0] ERR_FINE  = ERR_W'(Q_0_1);
    localparam logic signed [ERR_W-1:0] ERR_WRAP  = ERR_W'(Q_6_1);

    // Bearing constants
    localparam logic [HEAD_W-1:0] AIM_PI     = HEAD_W'(PI_Q);
    localparam logic [HEAD_W-1:0] AIM_TWO_PI = HEAD_W'(2 * PI_Q);

    // Turn speed magnitudes
    localparam logic signed [TURN_W-1:0] TURN_SLOW = TURN_W'(Q_0_05);
    localparam logic signed [TURN_W-1:0] TURN_MID  = TURN_W'(Q_0_3);
    localparam logic signed [TURN_W-1:0] TURN_FAST = TURN_W'(Q_0_8);

    // Forward speed steps
    localparam logic [FWD_W-1:0] FWD_SLOW = FWD_W'(Q_0_05);
    localparam logic [FWD_W-1:0] FWD_MID  = FWD_W'(Q_0_1);
    localparam logic [FWD_W-1:0] FWD_FAST = FWD_W'(Q_0_2);

    // Distance bands
    localparam logic [DIST_W-1:0] DIST_NEAR = DIST_W'(Q_0_3);
    localparam logic [DIST_W-1:0] DIST_LOW  = DIST_W'(Q_0_8);
    localparam logic [DIST_W-1:0] DIST_HIGH = DIST_W'(Q_2);

    // Angle accumulator rounding (Q32 down to FRACTION_BITS)
    localparam logic [Z_W-1:0] Z_RND   = Z_W'(longint'(1) << (31 - FRACTION_BITS));
    localparam int             Z_SHIFT = 32 - FRACTION_BITS;

    typedef struct packed {
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic [HEAD_W-1:0]       robot_heading;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic [HEAD_W-1:0]       target_heading;
        logic                    final_align;
    } pose_t;

    // Quadrant flags and headings riding along the pipeline
    typedef struct packed {
        logic              dx_neg;
        logic              dy_neg;
        logic              at_goal;
        logic [HEAD_W-1:0] robot_heading;
        logic [HEAD_W-1:0] target_heading;
        logic              final_align;
    } side_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
        side_t                  side;
    } cell_t;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn_speed;
        logic signed [ERR_W-1:0]  heading_error;
        logic [FWD_W-1:0]         forward_speed;
        logic [DIST_W-1:0]        goal_distance;
    } cmd_t;

    // atan(2^-i) with 32 fraction bits, rounded; 2^(32-i) from i = 11 on
    function automatic logic [Z_W-1:0] atan_q32(input logic [STAGE_W-1:0] i);
        logic [63:0] a;
        case (i)
            0:       a = 64'd3373259426;
            1:       a = 64'd1991351318;
            2:       a = 64'd1052175346;
            3:       a = 64'd534100635;
            4:       a = 64'd268086748;
            5:       a = 64'd134174063;
            6:       a = 64'd67103403;
            7:       a = 64'd33553749;
            8:       a = 64'd16777131;
            9:       a = 64'd8388597;
            10:      a = 64'd4194303;
            default: a = 64'h1_0000_0000 >> i;
        endcase
        return Z_W'(a);
    endfunction

endpackage

[hw/rtl/ghsc_pose_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_pose_if: pose and goal input channel
// Valid/ready channel carrying one pose sample per transfer.
// ----------------------------------------------------------------------------
interface ghsc_pose_if;
    logic                              valid;
    logic                              ready;
    logic signed [ghsc_pkg::POS_W-1:0] robot_x;
    logic signed [ghsc_pkg::POS_W-1:0] robot_y;
    logic [ghsc_pkg::HEAD_W-1:0]       robot_heading;
    logic signed [ghsc_pkg::POS_W-1:0] target_x;
    logic signed [ghsc_pkg::POS_W-1:0] target_y;
    logic [ghsc_pkg::HEAD_W-1:0]       target_heading;
    logic                              final_align;

    modport source (
        output valid, robot_x, robot_y, robot_heading,
        output target_x, target_y, target_heading, final_align,
        input  ready
    );

    modport sink (
        input  valid, robot_x, robot_y, robot_heading,
        input  target_x, target_y, target_heading, final_align,
        output ready
    );
endinterface

[hw/rtl/ghsc_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_cmd_if: speed command output channel
// Valid/ready channel carrying one command result per transfer.
// ----------------------------------------------------------------------------
interface ghsc_cmd_if;
    logic                               valid;
    logic                               ready;
    logic signed [ghsc_pkg::TURN_W-1:0] turn_speed;
    logic signed [ghsc_pkg::ERR_W-1:0]  heading_error;
    logic [ghsc_pkg::FWD_W-1:0]         forward_speed;
    logic [ghsc_pkg::DIST_W-1:0]        goal_distance;

    modport source (
        output valid, turn_speed, heading_error, forward_speed, goal_distance,
        input  ready
    );

    modport sink (
        input  valid, turn_speed, heading_error, forward_speed, goal_distance,
        output ready
    );
endinterface

[hw/rtl/ghsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_front: goal offset, magnitudes and squared distance
// Four elastic stages: offset, absolute value, squares, cell chain seed.
// ----------------------------------------------------------------------------
module ghsc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ghsc_pkg::pose_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ghsc_pkg::cell_t out_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [ghsc_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    ghsc_pkg::side_t                    side1_reg, side2_reg, side3_reg;
    logic [ghsc_pkg::DIFF_W-1:0]        ax_reg, ay_reg, ax3_reg, ay3_reg;
    logic [ghsc_pkg::SQ_W-1:0]          sqx_reg, sqy_reg;
    ghsc_pkg::cell_t                    seed_reg;

    logic signed [ghsc_pkg::DIFF_W-1:0] dx_next, dy_next;
    logic [ghsc_pkg::DIFF_W-1:0]        ax_next, ay_next;
    ghsc_pkg::side_t                    side1_next, side2_next;
    ghsc_pkg::cell_t                    seed_next;

    // Stage moves when empty or when the next one moves
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Offset to goal
    always_comb
    begin
        dx_next = $signed(ghsc_pkg::DIFF_W'(in_data.target_x))
                - $signed(ghsc_pkg::DIFF_W'(in_data.robot_x));
        dy_next = $signed(ghsc_pkg::DIFF_W'(in_data.target_y))
                - $signed(ghsc_pkg::DIFF_W'(in_data.robot_y));
        side1_next                = '0;
        side1_next.robot_heading  = in_data.robot_heading;
        side1_next.target_heading = in_data.target_heading;
        side1_next.final_align    = in_data.final_align;
    end

    // Magnitudes and quadrant
    always_comb
    begin
        ax_next = dx_reg[ghsc_pkg::DIFF_W-1] ? unsigned'(-dx_reg) : unsigned'(dx_reg);
        ay_next = dy_reg[ghsc_pkg::DIFF_W-1] ? unsigned'(-dy_reg) : unsigned'(dy_reg);
        side2_next         = side1_reg;
        side2_next.dx_neg  = dx_reg[ghsc_pkg::DIFF_W-1];
        side2_next.dy_neg  = dy_reg[ghsc_pkg::DIFF_W-1];
        side2_next.at_goal = (dx_reg == '0) && (dy_reg == '0);
    end

    // Seed for the cell chain: prescaled vector and squared length
    always_comb
    begin
        seed_next      = '0;
        seed_next.x    = signed'(ghsc_pkg::XY_W'({ax3_reg, {ghsc_pkg::PRE_SHIFT{1'b0}}}));
        seed_next.y    = signed'(ghsc_pkg::XY_W'({ay3_reg, {ghsc_pkg::PRE_SHIFT{1'b0}}}));
        seed_next.z    = '0;
        seed_next.rem  = sqx_reg + sqy_reg;
        seed_next.root = '0;
        seed_next.side = side3_reg;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= side1_next;
        end
        if (rdy2)
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            side2_reg <= side2_next;
        end
        if (rdy3)
        begin
            ax3_reg   <= ax_reg;
            ay3_reg   <= ay_reg;
            sqx_reg   <= ghsc_pkg::SQ_W'(ax_reg) * ghsc_pkg::SQ_W'(ax_reg);
            sqy_reg   <= ghsc_pkg::SQ_W'(ay_reg) * ghsc_pkg::SQ_W'(ay_reg);
            side3_reg <= side2_reg;
        end
        if (rdy4)
        begin
            seed_reg <= seed_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = seed_reg;

endmodule

[hw/rtl/ghsc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_cell: one cell of the angle and root chain
// One vectoring rotation (stages below ROT_COUNT) and one square-root digit (stages below ROOT_COUNT), registered.
// ----------------------------------------------------------------------------
module ghsc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ghsc_pkg::STAGE_W-1:0]  stage,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ghsc_pkg::cell_t               in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ghsc_pkg::cell_t               out_data
);

    logic            valid_reg;
    ghsc_pkg::cell_t data_reg;
    ghsc_pkg::cell_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic signed [ghsc_pkg::XY_W-1:0] x_cur;
        logic signed [ghsc_pkg::XY_W-1:0] y_cur;
        logic signed [ghsc_pkg::XY_W-1:0] xs;
        logic signed [ghsc_pkg::XY_W-1:0] ys;
        logic signed [ghsc_pkg::Z_W-1:0]  ang;
        logic [ghsc_pkg::STAGE_W:0]       b_shift;
        logic [ghsc_pkg::SQ_W-1:0]        bit_val;
        logic [ghsc_pkg::SQ_W-1:0]        trial;

        x_cur   = in_data.x;
        y_cur   = in_data.y;
        xs      = x_cur >>> stage;
        ys      = y_cur >>> stage;
        ang     = signed'(ghsc_pkg::atan_q32(stage));
        b_shift = {ghsc_pkg::ROOT_TOP - stage, 1'b0};
        bit_val = ghsc_pkg::SQ_W'(1) << b_shift;
        trial   = in_data.root + bit_val;

        data_next = in_data;

        // Rotate toward the x axis, accumulate the angle
        if (stage < ghsc_pkg::ROT_COUNT)
        begin
            if (!y_cur[ghsc_pkg::XY_W-1] && (y_cur != '0))
            begin
                data_next.x = x_cur + ys;
                data_next.y = y_cur - xs;
                data_next.z = in_data.z + ang;
            end
            else
            begin
                data_next.x = x_cur - ys;
                data_next.y = y_cur + xs;
                data_next.z = in_data.z - ang;
            end
        end

        // One root digit
        if (stage < ghsc_pkg::ROOT_COUNT)
        begin
            if (in_data.rem >= trial)
            begin
                data_next.rem  = in_data.rem - trial;
                data_next.root = (in_data.root >> 1) + bit_val;
            end
            else
            begin
                data_next.root = in_data.root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/ghsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghsc_back: bearing, heading error and speed selection
// Four elastic stages ending in the output register.
// ----------------------------------------------------------------------------
module ghsc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ghsc_pkg::cell_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ghsc_pkg::cmd_t  out_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [ghsc_pkg::HEAD_W-1:0]       t_reg, aim_reg, rh2_reg;
    ghsc_pkg::side_t                   side1_reg;
    logic [ghsc_pkg::DIST_W-1:0]       dist1_reg, dist2_reg, dist3_reg;
    logic [ghsc_pkg::FWD_W-1:0]        fwd1_reg, fwd2_reg, fwd3_reg;
    logic signed [ghsc_pkg::ERR_W-1:0] err_reg;
    ghsc_pkg::cmd_t                    cmd_reg;

    logic [ghsc_pkg::HEAD_W-1:0] t_next, aim_next;
    logic [ghsc_pkg::FWD_W-1:0]  fwd_next;
    logic [ghsc_pkg::DIST_W-1:0] dist_next;
    ghsc_pkg::cmd_t              cmd_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Clamp and round the angle sum; forward speed band
    always_comb
    begin
        logic [ghsc_pkg::Z_W-1:0] zc;
        zc        = in_data.z[ghsc_pkg::Z_W-1] ? '0 : unsigned'(in_data.z);
        t_next    = ghsc_pkg::HEAD_W'((zc + ghsc_pkg::Z_RND) >> ghsc_pkg::Z_SHIFT);
        dist_next = in_data.root[ghsc_pkg::DIST_W-1:0];
        if ((dist_next > ghsc_pkg::DIST_LOW) && (dist_next < ghsc_pkg::DIST_HIGH))
            fwd_next = ghsc_pkg::FWD_FAST;
        else if (dist_next < ghsc_pkg::DIST_NEAR)
            fwd_next = ghsc_pkg::FWD_SLOW;
        else
            fwd_next = ghsc_pkg::FWD_MID;
    end

    // Quadrant rule, zero at the goal, target heading under final_align; a bearing of exactly 2pi wraps to zero
    always_comb
    begin
        if (side1_reg.at_goal)
            aim_next = '0;
        else if (!side1_reg.dy_neg && !side1_reg.dx_neg)
            aim_next = t_reg;
        else if (!side1_reg.dy_neg)
            aim_next = ghsc_pkg::AIM_PI - t_reg;
        else if (!side1_reg.dx_neg)
            aim_next = (t_reg == '0) ? '0 : ghsc_pkg::AIM_TWO_PI - t_reg;
        else
            aim_next = ghsc_pkg::AIM_PI + t_reg;
        if (side1_reg.final_align)
            aim_next = side1_reg.target_heading;
    end

    // Turn speed magnitude and sign from the heading error
    always_comb
    begin
        logic                             fast;
        logic                             fine;
        logic                             wrap;
        logic                             neg;
        logic signed [ghsc_pkg::TURN_W-1:0] mag;
        fast = (err_reg < ghsc_pkg::ERR_PI53) && (err_reg > -ghsc_pkg::ERR_PI53)
            && ((err_reg > ghsc_pkg::ERR_PI3) || (err_reg < -ghsc_pkg::ERR_PI3));
        fine = (err_reg < ghsc_pkg::ERR_FINE) && (err_reg > -ghsc_pkg::ERR_FINE);
        wrap = (err_reg > ghsc_pkg::ERR_WRAP) || (err_reg < -ghsc_pkg::ERR_WRAP);
        if (fine || wrap)
            mag = ghsc_pkg::TURN_SLOW;
        else if (fast)
            mag = ghsc_pkg::TURN_FAST;
        else
            mag = ghsc_pkg::TURN_MID;
        if (err_reg > 0)
            neg = err_reg > ghsc_pkg::ERR_PI;
        else
            neg = err_reg > -ghsc_pkg::ERR_PI;
        cmd_next.turn_speed    = neg ? -mag : mag;
        cmd_next.heading_error = err_reg;
        cmd_next.forward_speed = fwd3_reg;
        cmd_next.goal_distance = dist3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            t_reg     <= t_next;
            side1_reg <= in_data.side;
            dist1_reg <= dist_next;
            fwd1_reg  <= fwd_next;
        end
        if (rdy2)
        begin
            aim_reg   <= aim_next;
            rh2_reg   <= side1_reg.robot_heading;
            dist2_reg <= dist1_reg;
            fwd2_reg  <= fwd1_reg;
        end
        if (rdy3)
        begin
            err_reg   <= $signed({1'b0, aim_reg}) - $signed({1'b0, rh2_reg});
            dist3_reg <= dist2_reg;
            fwd3_reg  <= fwd2_reg;
        end
        if (rdy4)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = cmd_reg;

`ifndef SYNTHESIS
    // Forward speed is always one of the three steps
    a_fwd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (cmd_reg.forward_speed == ghsc_pkg::FWD_SLOW
                 || cmd_reg.forward_speed == ghsc_pkg::FWD_MID
                 || cmd_reg.forward_speed == ghsc_pkg::FWD_FAST))
        else $error("forward speed off the step set");

    // Turn speed is one of six signed steps
    a_turn_legal: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (cmd_reg.turn_speed == ghsc_pkg::TURN_SLOW
                 || cmd_reg.turn_speed == -ghsc_pkg::TURN_SLOW
                 || cmd_reg.turn_speed == ghsc_pkg::TURN_MID
                 || cmd_reg.turn_speed == -ghsc_pkg::TURN_MID
                 || cmd_reg.turn_speed == ghsc_pkg::TURN_FAST
                 || cmd_reg.turn_speed == -ghsc_pkg::TURN_FAST))
        else $error("turn speed off the step set");

    // Zero heading error turns slowly in the negative sense
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && cmd_reg.heading_error == '0) |-> cmd_reg.turn_speed == -ghsc_pkg::TURN_SLOW)
        else $error("zero heading error gives wrong turn");

    // A far goal never gets the fast forward step
    a_far_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && cmd_reg.goal_distance >= ghsc_pkg::DIST_HIGH)
            |-> cmd_reg.forward_speed == ghsc_pkg::FWD_MID)
        else $error("far goal with wrong forward speed");
`endif

endmodule

[hw/rtl/goal_heading_speed_command.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goal_heading_speed_command: turn and forward speed command from pose/goal
// Goal bearing by a vectoring cell chain, distance by a digit-per-cell root,
// heading error and stepped speed commands.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+------------------------------------------------------------
//  pose    | in  | robot_x/y, robot_heading, target_x/y, target_heading, final_align
//  cmd     | out | turn_speed, heading_error, forward_speed, goal_distance
//
// One transfer per clock on each side while the output is not stalled. Four front
// stages, one cell per rotation or root digit (the larger of 18 rotations and 25
// digits), four back stages with the output register last. Reset clears only
// the valid flags. Each stage holds while the next one is full and stalled;
// empty stages fill, so input keeps flowing while a result waits at the output.
// ----------------------------------------------------------------------------
module goal_heading_speed_command (
    input  logic         clk,
    input  logic         rst_n,
    ghsc_pose_if.sink    pose,
    ghsc_cmd_if.source   cmd
);

    ghsc_pkg::pose_t pose_data;
    ghsc_pkg::cmd_t  cmd_data;

    ghsc_pkg::cell_t chain_data  [ghsc_pkg::NUM_CELLS+1];
    logic            chain_valid [ghsc_pkg::NUM_CELLS+1];
    logic            chain_ready [ghsc_pkg::NUM_CELLS+1];

    // Gather the input payload
    always_comb
    begin
        pose_data.robot_x        = pose.robot_x;
        pose_data.robot_y        = pose.robot_y;
        pose_data.robot_heading  = pose.robot_heading;
        pose_data.target_x       = pose.target_x;
        pose_data.target_y       = pose.target_y;
        pose_data.target_heading = pose.target_heading;
        pose_data.final_align    = pose.final_align;
    end

    ghsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pose.valid),
        .in_ready  (pose.ready),
        .in_data   (pose_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Row of cells, one step each
    for (genvar k = 0; k < ghsc_pkg::NUM_CELLS; k++)
    begin : g_cell
        ghsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (ghsc_pkg::STAGE_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    ghsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[ghsc_pkg::NUM_CELLS]),
        .in_ready  (chain_ready[ghsc_pkg::NUM_CELLS]),
        .in_data   (chain_data[ghsc_pkg::NUM_CELLS]),
        .out_valid (cmd.valid),
        .out_ready (cmd.ready),
        .out_data  (cmd_data)
    );

    // Spread the result payload
    assign cmd.turn_speed    = cmd_data.turn_speed;
    assign cmd.heading_error = cmd_data.heading_error;
    assign cmd.forward_speed = cmd_data.forward_speed;
    assign cmd.goal_distance = cmd_data.goal_distance;

endmodule
